/* design/bbd_pkg.sv */
package bbd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int SIZE_BITS   = 13;
   localparam int POS_BITS    = 12;
   localparam int Q_BITS      = 18;
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int RUN_SLOTS   = 4;

   // register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // result slots of one item, in delivery order
   localparam int SLOT_UP_LEFT  = 0;   // (x-1, y-1)
   localparam int SLOT_UP_HERE  = 1;   // (x,   y-1), last column
   localparam int SLOT_ROW_LEFT = 2;   // (x-1, y),   last row
   localparam int SLOT_ROW_HERE = 3;   // (x,   y),   last column and row

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [2:0]       row_type;
   typedef row_type [2:0]          window_type;   // [row][col], index 0 oldest
   typedef logic [Q_BITS-1:0]      q_type;
   typedef logic [POS_BITS-1:0]    pos_type;
   typedef logic [SIZE_BITS-1:0]   size_type;
   typedef logic [RUN_SLOTS-1:0]   slot_mask_type;

   typedef struct packed {
      logic col_at_x;        // pixel column is the newest window column
      logic col_near_edge;   // window base column sits at -1
      logic row_at_y;
      logic row_near_edge;
      logic odd_col;
      logic odd_row;
   } tap_sel_type;

endpackage

/* design/bbd_interp.sv */
module bbd_interp (
   input  bbd_pkg::window_type  window,
   input  bbd_pkg::tap_sel_type sel,
   output bbd_pkg::q_type       red_q2,
   output bbd_pkg::q_type       green_q2,
   output bbd_pkg::q_type       blue_q2
);
   import bbd_pkg::*;

   function automatic row_type pick_row(window_type w, logic [1:0] i);
      case (i)
         2'd0:    pick_row = w[0];
         2'd1:    pick_row = w[1];
         default: pick_row = w[2];
      endcase
   endfunction

   function automatic sample_type pick_tap(row_type r, logic [1:0] i);
      case (i)
         2'd0:    pick_tap = r[0];
         2'd1:    pick_tap = r[1];
         default: pick_tap = r[2];
      endcase
   endfunction

   logic [1:0] cl, cc, cr, ru, rc, rd;
   row_type    up_row, mid_row, dn_row;
   sample_type c, l, r, u, d, ul, ur, dl, dr;
   q_type      orth, diag, centre4, lr2, ud2;

   always_comb begin
      // reflection by two lands the missing neighbour on the opposite tap
      cc = sel.col_at_x ? 2'd2 : 2'd1;
      cr = sel.col_at_x ? 2'd1 : 2'd2;
      cl = sel.col_at_x ? 2'd1 : (sel.col_near_edge ? 2'd2 : 2'd0);
      rc = sel.row_at_y ? 2'd2 : 2'd1;
      rd = sel.row_at_y ? 2'd1 : 2'd2;
      ru = sel.row_at_y ? 2'd1 : (sel.row_near_edge ? 2'd2 : 2'd0);

      up_row  = pick_row(window, ru);
      mid_row = pick_row(window, rc);
      dn_row  = pick_row(window, rd);

      c  = pick_tap(mid_row, cc);
      l  = pick_tap(mid_row, cl);
      r  = pick_tap(mid_row, cr);
      u  = pick_tap(up_row, cc);
      d  = pick_tap(dn_row, cc);
      ul = pick_tap(up_row, cl);
      ur = pick_tap(up_row, cr);
      dl = pick_tap(dn_row, cl);
      dr = pick_tap(dn_row, cr);

      orth    = Q_BITS'(l) + Q_BITS'(r) + Q_BITS'(u) + Q_BITS'(d);
      diag    = Q_BITS'(ul) + Q_BITS'(ur) + Q_BITS'(dl) + Q_BITS'(dr);
      centre4 = {c, 2'b00};
      lr2     = (Q_BITS'(l) + Q_BITS'(r)) << 1;
      ud2     = (Q_BITS'(u) + Q_BITS'(d)) << 1;

      case ({sel.odd_row, sel.odd_col})
         2'b00: begin   // red site
            red_q2 = centre4; green_q2 = orth; blue_q2 = diag;
         end
         2'b01: begin   // green, red row
            red_q2 = lr2; green_q2 = centre4; blue_q2 = ud2;
         end
         2'b10: begin   // green, blue row
            red_q2 = ud2; green_q2 = centre4; blue_q2 = lr2;
         end
         default: begin // blue site
            red_q2 = diag; green_q2 = orth; blue_q2 = centre4;
         end
      endcase
   end

endmodule

/* design/bayer_bilinear_demosaic.sv */
// An accepted item is registered in stage 1, then enters the stage 2 window, and its results
// go to the single result register. One item per cycle while rsp_ready holds; an item causing
// several results (up to four, at last column and last row) holds the input until all are sent.
// Reset (synchronous, active high): position counters, 3x3 window and valid flags cleared,
// image size back to 4096 x 4096. Line stores are not cleared and need no clearing pass.
module bayer_bilinear_demosaic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  bbd_pkg::size_type    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bbd_pkg::sample_type  req_raw_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbd_pkg::q_type       rsp_red_q2,
   output bbd_pkg::q_type       rsp_green_q2,
   output bbd_pkg::q_type       rsp_blue_q2,
   output bbd_pkg::pos_type     rsp_pixel_col,
   output bbd_pkg::pos_type     rsp_pixel_row,
   output logic                 rsp_last_in_run
);
   import bbd_pkg::*;

   // ---------------- configuration ----------------
   size_type image_width_ff, image_height_ff;
   size_type width_eff, height_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= SIZE_BITS'(MAX_WIDTH);
         image_height_ff <= SIZE_BITS'(MAX_HEIGHT);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // sizes out of range are pinned to 3 and to the maximum
   always_comb begin
      if (image_width_ff < SIZE_BITS'(3))
         width_eff = SIZE_BITS'(3);
      else if (image_width_ff > SIZE_BITS'(MAX_WIDTH))
         width_eff = SIZE_BITS'(MAX_WIDTH);
      else
         width_eff = image_width_ff;
      if (image_height_ff < SIZE_BITS'(3))
         height_eff = SIZE_BITS'(3);
      else if (image_height_ff > SIZE_BITS'(MAX_HEIGHT))
         height_eff = SIZE_BITS'(MAX_HEIGHT);
      else
         height_eff = image_height_ff;
   end

   // ---------------- handshake and pipeline control ----------------
   logic          req_accept;
   logic          s1_valid_ff, s2_valid_ff;
   logic          s1_move, s2_free, s2_done;
   logic          out_load, emit, emit_last;
   slot_mask_type s2_mask_ff, pick;

   // ---------------- position counters ----------------
   pos_type       col_ff, row_ff, col_in, row_in;
   pos_type       x_cur, y_cur;
   size_type      row_step;
   logic          col_wrap, last_col, last_row;
   slot_mask_type mask_in;

   always_comb begin
      // counters left outside a new size wrap before use
      col_wrap = {1'b0, col_ff} >= width_eff;
      x_cur    = col_wrap ? '0 : col_ff;
      row_step = {1'b0, row_ff} + SIZE_BITS'(col_wrap);
      y_cur    = (row_step >= height_eff) ? '0 : row_step[POS_BITS-1:0];
      last_col = {1'b0, x_cur} == (width_eff - SIZE_BITS'(1));
      last_row = {1'b0, y_cur} == (height_eff - SIZE_BITS'(1));

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : y_cur + POS_BITS'(1);
      end else begin
         col_in = x_cur + POS_BITS'(1);
         row_in = y_cur;
      end

      mask_in                = '0;
      mask_in[SLOT_UP_LEFT]  = (y_cur != '0) && (x_cur != '0);
      mask_in[SLOT_UP_HERE]  = (y_cur != '0) && last_col;
      mask_in[SLOT_ROW_LEFT] = last_row && (x_cur != '0);
      mask_in[SLOT_ROW_HERE] = last_row && last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line stores ----------------
   // read at accept, written back when the item enters the window
   sample_type    line_upper_mem [MAX_WIDTH];
   sample_type    line_lower_mem [MAX_WIDTH];
   sample_type    upper_rd_ff, lower_rd_ff;
   sample_type    s1_sample_ff;
   pos_type       s1_x_ff, s1_y_ff;
   slot_mask_type s1_mask_ff;

   always_ff @(posedge clock) begin
      if (req_accept)
         upper_rd_ff <= line_upper_mem[x_cur[ADDR_BITS-1:0]];
      if (s1_move)
         line_upper_mem[s1_x_ff[ADDR_BITS-1:0]] <= lower_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (req_accept)
         lower_rd_ff <= line_lower_mem[x_cur[ADDR_BITS-1:0]];
      if (s1_move)
         line_lower_mem[s1_x_ff[ADDR_BITS-1:0]] <= s1_sample_ff;
   end

   // ---------------- stage 1: accepted item ----------------
   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_accept)
         s1_valid_ff <= 1'b1;
      else if (s1_move)
         s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_raw_sample;
         s1_x_ff      <= x_cur;
         s1_y_ff      <= y_cur;
         s1_mask_ff   <= mask_in;
      end
   end

   // ---------------- stage 2: window and result run ----------------
   window_type window_ff;
   pos_type    s2_x_ff, s2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_move) begin
         for (int r = 0; r < 3; r++) begin
            window_ff[r][0] <= window_ff[r][1];
            window_ff[r][1] <= window_ff[r][2];
         end
         window_ff[0][2] <= upper_rd_ff;
         window_ff[1][2] <= lower_rd_ff;
         window_ff[2][2] <= s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_mask_ff  <= '0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
         s2_mask_ff  <= s1_mask_ff;
      end else if (s2_done) begin
         s2_valid_ff <= 1'b0;
         s2_mask_ff  <= '0;
      end else if (emit) begin
         s2_mask_ff  <= s2_mask_ff & ~pick;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_x_ff <= s1_x_ff;
         s2_y_ff <= s1_y_ff;
      end
   end

   // next pending slot, lowest first
   always_comb begin
      pick = '0;
      for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
         if (s2_mask_ff[i])
            pick = slot_mask_type'(1) << i;
      end
   end

   always_comb begin
      out_load   = !rsp_valid || rsp_ready;
      emit       = s2_valid_ff && (s2_mask_ff != '0) && out_load;
      emit_last  = (s2_mask_ff & ~pick) == '0;
      // an item with no results leaves at once
      s2_done    = s2_valid_ff && ((s2_mask_ff == '0) || (emit && emit_last));
      s2_free    = !s2_valid_ff || s2_done;
      s1_move    = s1_valid_ff && s2_free;
      req_ready  = !s1_valid_ff || s1_move;
      req_accept = req_valid && req_ready;
   end

   tap_sel_type sel;
   pos_type     px, py;
   q_type       red_c, green_c, blue_c;

   always_comb begin
      sel.col_at_x      = pick[SLOT_UP_HERE] | pick[SLOT_ROW_HERE];
      sel.row_at_y      = pick[SLOT_ROW_LEFT] | pick[SLOT_ROW_HERE];
      sel.col_near_edge = s2_x_ff == POS_BITS'(1);
      sel.row_near_edge = s2_y_ff == POS_BITS'(1);
      px                = sel.col_at_x ? s2_x_ff : s2_x_ff - POS_BITS'(1);
      py                = sel.row_at_y ? s2_y_ff : s2_y_ff - POS_BITS'(1);
      sel.odd_col       = px[0];
      sel.odd_row       = py[0];
   end

   bbd_interp u_interp (
      .window   (window_ff),
      .sel      (sel),
      .red_q2   (red_c),
      .green_q2 (green_c),
      .blue_q2  (blue_c)
   );

   // ---------------- result register ----------------
   logic    rsp_valid_ff, rsp_last_ff;
   q_type   rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   pos_type rsp_col_ff, rsp_row_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (emit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_red_ff   <= red_c;
         rsp_green_ff <= green_c;
         rsp_blue_ff  <= blue_c;
         rsp_col_ff   <= px;
         rsp_row_ff   <= py;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_q2      = rsp_red_ff;
   assign rsp_green_q2    = rsp_green_ff;
   assign rsp_blue_q2     = rsp_blue_ff;
   assign rsp_pixel_col   = rsp_col_ff;
   assign rsp_pixel_row   = rsp_row_ff;
   assign rsp_last_in_run = rsp_last_ff;

endmodule
